// ===== src/msrt_pkg.sv =====
// msrt_pkg: shared types, widths, constants and mu-law codec functions
// for the soft clip / mu-law round trip block. No dependencies.
package msrt_pkg;

  // Magnitude of an unclipped product (<= 3*2^26) and derived widths
  localparam int MagW = 28;
  localparam int X2W  = 30;
  localparam int SumW = 32;
  localparam int NumW = 59;
  localparam int DenW = 33;
  localparam int QW   = 27;

  localparam logic [SumW-1:0] K27_Q26    = 32'h6C00_0000;  // 27 * 2^26
  localparam logic [30:0]     CLIP_LIMIT = 31'h0C00_0000;  // 3 * 2^26
  localparam logic [14:0]     PCM_FULL   = 15'd32767;
  localparam logic [13:0]     MU_CLAMP   = 14'd8159;
  localparam logic [13:0]     MU_BIAS    = 14'd33;
  localparam logic [15:0]     MU_K84     = 16'h0084;
  localparam logic [7:0]      MASK_NEG   = 8'h7F;
  localparam logic [7:0]      MASK_POS   = 8'hFF;
  localparam logic [7:0]      SEG_OVER   = 8'h7F;

  typedef struct packed {
    logic               byp;
    logic               neg;
    logic               clip;
    logic signed [15:0] sample;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [MagW-1:0] mag;
  } fq_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } fq_stat_t;

  // G.711 style mu-law encoder
  function automatic logic [7:0] mu_encode(input logic signed [15:0] pcm);
    logic signed [15:0] sh2;
    logic signed [13:0] v;
    logic [13:0] m;
    logic [13:0] val;
    logic [13:0] sh;
    logic [7:0]  mask;
    logic [2:0]  seg;
    logic        found;
    sh2 = pcm >>> 2;
    v = sh2[13:0];
    if (v[13]) begin
      mask = MASK_NEG;
      m = 14'(-v);
    end else begin
      mask = MASK_POS;
      m = v;
    end
    if (m > MU_CLAMP) m = MU_CLAMP;
    val = m + MU_BIAS;
    seg = 3'd0;
    found = 1'b0;
    // descending scan leaves the smallest fitting segment
    for (int s = 7; s >= 0; s--) begin
      if (val <= 14'((64 << s) - 1)) begin
        seg = 3'(s);
        found = 1'b1;
      end
    end
    sh = val >> ({1'b0, seg} + 4'd1);
    return found ? ({1'b0, seg, sh[3:0]} ^ mask) : (SEG_OVER ^ mask);
  endfunction

  // mu-law expander back to linear PCM
  function automatic logic [15:0] mu_decode(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    u = ~code;
    t = (16'({u[3:0], 3'b000}) + MU_K84) << u[6:4];
    return u[7] ? (MU_K84 - t) : (t - MU_K84);
  endfunction

endpackage

// ===== src/msrt_front.sv =====
// msrt_front: accepts input beats, forms the exact product and classifies it
// (sign, clip, magnitude). Depends on msrt_pkg.
module msrt_front import msrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] in_gain,
  input  logic               bypass,
  output logic               push_valid,
  input  logic               push_ready,
  output fq_t                push_data
);

  logic               v_r;
  logic signed [31:0] p_r, p_nxt;
  logic signed [15:0] s_r;
  logic               byp_r;
  logic [30:0]        m;

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;
  assign p_nxt      = in_sample * in_gain;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      p_r   <= p_nxt;
      s_r   <= in_sample;
      byp_r <= bypass;
    end
  end

  // classify: sign, magnitude, clip
  always_comb begin
    m = p_r[31] ? 31'(-p_r) : p_r[30:0];
    push_data.meta.byp    = byp_r;
    push_data.meta.neg    = p_r[31];
    push_data.meta.clip   = (m > CLIP_LIMIT);
    push_data.meta.sample = s_r;
    push_data.mag         = m[MagW-1:0];
  end

endmodule

// ===== src/msrt_fifo.sv =====
// msrt_fifo: two-entry queue between front and back end.
// Depends on msrt_pkg.
module msrt_fifo import msrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  fq_t      push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output fq_t      pop_data,
  output fq_stat_t stat
);

  fq_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  always_comb begin
    stat.count = cnt_r;
    stat.full  = !push_ready;
    stat.empty = !pop_valid;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== src/msrt_back.sv =====
// msrt_back: soft clip curve with a pipelined restoring divider, PCM scaling
// and the mu-law round trip; one output register. Depends on msrt_pkg.
module msrt_back import msrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  fq_t         pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pcm_out,
  output logic [7:0]  out_mu_code
);

  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // stage A: x^2
  logic            va_r;
  meta_t           ma_r;
  logic [MagW-1:0] mga_r;
  logic [X2W-1:0]  x2a_r;
  logic [2*MagW-1:0] sq;
  assign sq = pop_data.mag * pop_data.mag;

  // stage B (divider index 0): numerator and denominator
  logic [SumW-1:0] sum;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic [MagW+SumW-1:0] prod;
  assign sum  = K27_Q26 + SumW'(x2a_r);
  assign prod = mga_r * sum;
  assign num  = prod[NumW-1:0];
  assign den  = DenW'(K27_Q26) + DenW'(x2a_r) * DenW'(9);

  // divider stages; remainder and divisor are only needed up to the last step
  logic            vd_r   [QW+1];
  meta_t           md_r   [QW+1];
  logic [DenW-1:0] rd_r   [QW];
  logic [QW-1:0]   wd_r   [QW+1];
  logic [DenW-1:0] dd_r   [QW];
  logic [DenW-1:0] rd_nxt [QW];
  logic [QW-1:0]   wd_nxt [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      logic [DenW:0] t;
      logic          ge;
      t  = {rd_r[i], wd_r[i][QW-1]};
      ge = (t >= {1'b0, dd_r[i]});
      rd_nxt[i] = ge ? DenW'(t - {1'b0, dd_r[i]}) : t[DenW-1:0];
      wd_nxt[i] = {wd_r[i][QW-2:0], ge};
    end
  end

  // stage E: scale by 32767 and restore sign
  logic               ve_r;
  meta_t              me_r;
  logic signed [15:0] pe_r;
  logic [QW+15-1:0]   scl;
  logic [14:0]        mag;
  assign scl = ({wd_r[QW], 15'd0}) - (QW+15)'(wd_r[QW]);
  assign mag = md_r[QW].clip ? PCM_FULL : scl[26 +: 15];

  // output stage: mu-law encode and expand, or pass the sample through with code 0 in bypass
  logic        vo_r;
  logic [15:0] po_r;
  logic [7:0]  co_r;
  logic [7:0]  code;
  assign code = mu_encode(pe_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      for (int i = 0; i <= QW; i++) vd_r[i] <= 1'b0;
      ve_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r    <= pop_valid;
      vd_r[0] <= va_r;
      for (int i = 0; i < QW; i++) vd_r[i+1] <= vd_r[i];
      ve_r <= vd_r[QW];
      vo_r <= ve_r;
    end
    if (en) begin
      ma_r  <= pop_data.meta;
      mga_r <= pop_data.mag;
      x2a_r <= sq[26 +: X2W];
      md_r[0] <= ma_r;
      rd_r[0] <= DenW'(num[NumW-1:QW]);
      wd_r[0] <= num[QW-1:0];
      dd_r[0] <= den;
      for (int i = 0; i < QW; i++) begin
        md_r[i+1] <= md_r[i];
        wd_r[i+1] <= wd_nxt[i];
      end
      for (int i = 0; i < QW-1; i++) begin
        rd_r[i+1] <= rd_nxt[i];
        dd_r[i+1] <= dd_r[i];
      end
      me_r <= md_r[QW];
      pe_r <= md_r[QW].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      if (me_r.byp) begin
        po_r <= me_r.sample;
        co_r <= 8'd0;
      end else begin
        po_r <= mu_decode(code);
        co_r <= code;
      end
    end
  end

  assign out_valid   = vo_r;
  assign out_pcm_out = po_r;
  assign out_mu_code = co_r;

endmodule

// ===== src/mulaw_softclip_roundtrip_unit.sv =====
// mulaw_softclip_roundtrip_unit: top level tying the front end, queue and
// back end together. Depends on msrt_pkg, msrt_front, msrt_fifo, msrt_back.
//
// Usage:
//  - Input channel in_valid/in_ready carries in_sample (Q1.15) and in_gain
//    (Q5.11); one beat gives exactly one result beat.
//  - Result channel out_valid/out_ready carries out_pcm_out and out_mu_code.
//  - Config channel cfg_valid/cfg_ready writes the bypass bit (cfg_data);
//    cfg_ready is always high. Write only while the block is empty.
//  - Throughput: one beat per cycle sustained while out_ready stays high.
//  - Path from input accept to output valid: one product stage, the
//    queue, x^2 and numerator stages, 27 restoring divider stages (one
//    quotient bit each), the scaling stage and the codec output register.
//  - When the receiver stalls the back pipeline holds; the front end keeps
//    accepting until the two-entry queue and its product stage are full.
//  - Synchronous active-low reset empties all stages and clears bypass.
module mulaw_softclip_roundtrip_unit import msrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] in_gain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pcm_out,
  output logic [7:0]         out_mu_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic     bypass_r;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  fq_t      push_data, pop_data;
  fq_stat_t fstat;

  assign cfg_ready = 1'b1;

  // bypass register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bypass_r <= cfg_data;
    end
  end

  msrt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_gain,
    .bypass(bypass_r), .push_valid, .push_ready, .push_data
  );

  msrt_fifo u_fifo (
    .clk, .rst_n, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data, .stat(fstat)
  );

  msrt_back u_back (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_data,
    .out_valid, .out_ready, .out_pcm_out, .out_mu_code
  );

  // queue never overfills, and full agrees with the count
  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count != 2'd3 && (fstat.full == (fstat.count == 2'd2)))
    else $error("queue count out of range");

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pcm_out) && $stable(out_mu_code))
    else $error("result changed while stalled");

  // the front is never stalled while the queue has room
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !fstat.full |-> in_ready)
    else $error("input stalled with room in queue");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for mulaw_softclip_roundtrip_unit.
// Depends on msrt_pkg and the RTL; drives directed and random beats and
// checks each result against an in-bench soft clip / mu-law predictor.
module testbench;
  import msrt_pkg::*;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic [7:0]         code;
  } mu_result_t;

  localparam int LATENCY   = 32;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic signed [15:0] in_gain = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_pcm_out;
  logic [7:0] out_mu_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  mu_result_t expected_q[$];
  logic bypass_mode;
  int err_count;
  int cycle_count;
  bit idle_enable;

  mulaw_softclip_roundtrip_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_gain(in_gain),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pcm_out(out_pcm_out), .out_mu_code(out_mu_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("mulaw_softclip_roundtrip_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    err_count++;
  endtask

  // soft clip, scale to PCM, encode, expand (bypass returns the sample and code 0)
  function automatic mu_result_t predict_roundtrip(input logic signed [15:0] s,
                                                   input logic signed [15:0] g);
    mu_result_t r;
    logic signed [31:0] prod;
    logic [31:0] mag_in;
    logic [63:0] x2, num, den, y, mag;
    logic signed [31:0] pcm, v;
    logic [31:0] val, t;
    logic [7:0] mask, u;
    int seg;
    if (bypass_mode) begin
      r.pcm = s;
      r.code = 8'h00;
      return r;
    end
    prod = 32'(s) * 32'(g);
    mag_in = prod[31] ? 32'(-prod) : 32'(prod);
    if (64'(mag_in) > (64'd3 << 26)) begin
      mag = 64'd32767;
    end else begin
      x2 = (64'(mag_in) * 64'(mag_in)) >> 26;
      num = 64'(mag_in) * ((64'd27 << 26) + x2);
      den = (64'd27 << 26) + 64'd9 * x2;
      y = num / den;
      mag = (y * 64'd32767) >> 26;
    end
    pcm = prod[31] ? -32'(mag) : 32'(mag);
    // encoder
    v = pcm >>> 2;
    mask = 8'hFF;
    if (v < 0) begin
      v = -v;
      mask = 8'h7F;
    end
    if (v > 8159) v = 8159;
    val = 32'(v) + 33;
    seg = 0;
    while (seg < 8 && val > ((32'd64 << seg) - 1)) seg++;
    if (seg >= 8) r.code = 8'h7F ^ mask;
    else r.code = {1'b0, 3'(seg), 4'((val >> (seg + 1)) & 15)} ^ mask;
    // decoder
    u = ~r.code;
    t = ((32'(u[3:0]) << 3) + 32'h84) << u[6:4];
    r.pcm = u[7] ? 16'(32'h84 - t) : 16'(t - 32'h84);
    return r;
  endfunction

  // result checker with random receiver stalls
  initial begin : result_check
    mu_result_t exp_r;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_r = expected_q.pop_front();
          if (out_pcm_out !== exp_r.pcm)
            report_mismatch($sformatf("pcm_out got %0d exp %0d", out_pcm_out, exp_r.pcm));
          if (out_mu_code !== exp_r.code)
            report_mismatch($sformatf("mu_code got %02h exp %02h", out_mu_code, exp_r.code));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        stall = $urandom_range(1, 19);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // send one beat, with an optional idle burst first
  task automatic send_sample(input logic signed [15:0] s, input logic signed [15:0] g);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_gain <= g;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_roundtrip(s, g));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_bypass(input logic b);
    cfg_valid <= 1'b1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bypass_mode = b;
  endtask

  task automatic test_directed_corners();
    send_sample(16'sh8000, 16'sh8000);  // extreme operands, far past clip
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0000, 16'sh7FFF);
    send_sample(16'shFFFF, 16'sh0001);
    send_sample(16'sh0001, 16'sh0001);
    send_sample(16'sh4000, 16'sh3000);  // exactly +3
    send_sample(16'shC000, 16'sh3000);  // exactly -3
    send_sample(16'sh4000, 16'sh3001);  // just past +3
    send_sample(16'sh4000, 16'sh0800);  // x = 0.5
    send_sample(16'sh7FFF, 16'sh0800);  // near unity
    send_sample(16'sh8000, 16'sh0800);  // -1
    send_sample(16'sh5555, 16'shFFFF);
    send_sample(16'shAAAA, 16'sh5555);
  endtask

  task automatic test_bypass_passthrough();
    write_bypass(1'b1);
    send_sample(16'sh8000, 16'sh1234);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh7FFF);
    send_sample(16'shA5A5, 16'sh5A5A);
    repeat (40) send_sample(16'($urandom), 16'($urandom));
    drain_results();
    write_bypass(1'b0);
  endtask

  task automatic test_random_drive(input int count);
    logic signed [15:0] s, g;
    for (int i = 0; i < count; i++) begin
      s = 16'($urandom);
      case ($urandom_range(0, 3))
        0: g = 16'($urandom);
        1: g = 16'($urandom_range(0, 4096)) - 16'sd2048;  // gains from -1.0 to +1.0
        2: g = 16'($urandom_range(0, 255)) - 16'sd128;   // small drive
        default: g = $urandom_range(0, 1) ? 16'sh3000 : 16'shD000;
      endcase
      send_sample(s, g);
    end
  endtask

  task automatic test_pause_until_empty();
    test_random_drive(30);
    drain_results();
    test_random_drive(30);
  endtask

  initial begin : stimulus
    err_count = 0;
    cycle_count = 0;
    bypass_mode = 1'b0;
    idle_enable = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    drain_results();
    write_bypass(1'b0);
    test_bypass_passthrough();
    test_random_drive(250);
    test_pause_until_empty();
    idle_enable = 1'b0;
    test_random_drive(150);
    drain_results();
    if (err_count == 0) begin
      $display("mulaw_softclip_roundtrip_unit verification clean");
    end else begin
      $display("mulaw_softclip_roundtrip_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== mulaw_softclip_roundtrip_unit.f =====
src/msrt_pkg.sv
src/msrt_front.sv
src/msrt_fifo.sv
src/msrt_back.sv
src/mulaw_softclip_roundtrip_unit.sv
tb/testbench.sv
